// ===== design/ndrt_pkg.sv =====
// Shared types and constants for the neighbour delivery ratio table.
// Used by the top level and the iterative divider; no dependencies.
package ndrt_pkg;

  localparam int SRC_W  = 16;  // width of the address field on the ports
  localparam int ID_W   = 5;
  localparam int NUM_W  = 15;  // avg * div + score
  localparam int DEN_W  = 9;   // div + 1

  typedef enum logic [1:0] {
    CMD_PKT  = 2'd0,
    CMD_EVAL = 2'd1,
    CMD_RPT  = 2'd2,
    CMD_RSVD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_PKT  = 2'd0,
    KIND_EVAL = 2'd1,
    KIND_RPT  = 2'd2
  } kind_e;

  localparam logic [2:0] ST_SLOT1 = 3'd0;
  localparam logic [2:0] ST_SLOT2 = 3'd1;
  localparam logic [2:0] ST_SLOT3 = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_DROP  = 3'd4;

  localparam logic [6:0] SCORE_ALL  = 7'd100;
  localparam logic [6:0] SCORE_SOME = 7'd66;
  localparam logic [6:0] SCORE_NONE = 7'd33;
  localparam logic [6:0] AVG_INIT   = 7'd100;
  localparam logic [7:0] DIV_INIT   = 8'd1;

  // count * 25 / 9 as (count * 91025) >> 15, slightly above 2^15 * 25 / 9 so
  // that the floor stays exact for every 8-bit count
  localparam logic [16:0] RATIO_MUL   = 17'd91025;
  localparam int          RATIO_SHIFT = 15;

  typedef struct packed {
    logic [7:0] recv;
    logic [7:0] slot1;
    logic [7:0] slot2;
    logic [7:0] slot3;
    logic [6:0] avg;
    logic [7:0] div;
  } rec_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  entry_id;
    logic [SRC_W-1:0] entry_addr;
    logic [2:0]       pkt_status;
    logic [7:0]       recv_count;
    logic [6:0]       score;
    logic [6:0]       ratio_avg;
    logic [7:0]       divider_out;
    logic [9:0]       report_ratio;
    logic             last;
  } out_t;

endpackage

// ===== design/ndrt_div.sv =====
// Restoring divider for the running average, one quotient bit per cycle.
// Depends on ndrt_pkg for operand widths.
module ndrt_div import ndrt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== design/neighbor_delivery_ratio_table.sv =====
// Neighbour delivery ratio table: top level with FSM and entry memories.
// Depends on ndrt_pkg and ndrt_div.
//
// One transaction is handled at a time. A packet walks the address memory one
// entry per cycle (one read a cycle), then writes the entry back. An evaluate
// tick waits on the 15-step divider for the running average. A report tick
// emits one result per cycle per entry, as the downstream side takes them. No
// clearing pass after reset: entries are only read once allocated.
module neighbor_delivery_ratio_table import ndrt_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // src_addr[15:0], seq_no[23:16]
  input  logic [1:0]  s_axis_tuser_i,  // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // entry_id[4:0], entry_addr[20:5], pkt_status[23:21], recv_count[31:24],
  // score[38:32], ratio_avg[45:39], divider_out[53:46], report_ratio[63:54]
  output logic [63:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // kind[1:0]
  output logic        m_axis_tlast_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (ADDR_BITS < SRC_W) ? ADDR_BITS : SRC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PKT, S_DROP, S_EVAL, S_DIV, S_EOUT, S_RPT
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  pend_q, pend_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           alloc_q, alloc_d;
  logic [AW-1:0]  in_addr_q, in_addr_d;
  logic [7:0]     in_seq_q, in_seq_d;
  logic [6:0]     score_q, score_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;

  logic [AW-1:0]  addr_mem [TABLE_DEPTH];
  rec_t           data_mem [TABLE_DEPTH];
  logic [AW-1:0]  addr_rd_q;
  rec_t           rec_rd_q;

  logic           rd_en, wr_en, awr_en;
  logic [IW-1:0]  rd_idx;
  rec_t           wr_rec, base, upd;
  logic           out_free, last_idx;
  logic [IW-1:0]  pend_idx;
  logic [8:0]     sa1, sa2, sb1;
  logic           p1, p2, p3;
  logic [6:0]     sc;
  logic           div_start, div_busy;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic [2:0]     slot_st;
  logic [24:0]    ratio_prod;
  logic [ID_W-1:0] out_id;

  ndrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign last_idx = (CW'(idx_q) + CW'(1)) == count_q;
  assign pend_idx = IW'(pend_q - CW'(1));
  assign out_id   = ID_W'(idx_q) + ID_W'(1);

  // score of the three slots, sums taken without wrap
  always_comb begin
    sa1 = {1'b0, rec_rd_q.slot1} + 9'd1;
    sa2 = {1'b0, rec_rd_q.slot1} + 9'd2;
    sb1 = {1'b0, rec_rd_q.slot2} + 9'd1;
    p1  = sa1 == {1'b0, rec_rd_q.slot2};
    p2  = sb1 == {1'b0, rec_rd_q.slot3};
    p3  = sa2 == {1'b0, rec_rd_q.slot3};
    if (p1 && p2 && p3)      sc = SCORE_ALL;
    else if (p1 || p2 || p3) sc = SCORE_SOME;
    else                     sc = SCORE_NONE;
  end

  assign div_num    = NUM_W'(rec_rd_q.avg) * NUM_W'(rec_rd_q.div) + NUM_W'(sc);
  assign div_den    = {1'b0, rec_rd_q.div} + DEN_W'(1);
  assign ratio_prod = 25'(rec_rd_q.recv) * 25'(RATIO_MUL);

  // packet update of the entry: fresh record on allocation
  always_comb begin
    if (alloc_q) begin
      base = '{recv: 8'd0, slot1: 8'd0, slot2: 8'd0, slot3: 8'd0,
               avg: AVG_INIT, div: DIV_INIT};
    end else begin
      base = rec_rd_q;
    end
    upd      = base;
    upd.recv = base.recv + 8'd1;
    if (base.slot1 == 8'd0) begin
      upd.slot1 = in_seq_q;
      slot_st   = ST_SLOT1;
    end else if (base.slot2 == 8'd0) begin
      upd.slot2 = in_seq_q;
      slot_st   = ST_SLOT2;
    end else if (base.slot3 == 8'd0) begin
      upd.slot3 = in_seq_q;
      slot_st   = ST_SLOT3;
    end else begin
      slot_st   = ST_FULL;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pend_d      = pend_q;
    idx_d       = idx_q;
    alloc_d     = alloc_q;
    in_addr_d   = in_addr_q;
    in_seq_d    = in_seq_q;
    score_d     = score_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    rd_en       = 1'b0;
    rd_idx      = '0;
    wr_en       = 1'b0;
    awr_en      = 1'b0;
    wr_rec      = rec_rd_q;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          in_addr_d = AW'(s_axis_tdata_i[SRC_W-1:0]);
          in_seq_d  = s_axis_tdata_i[23:16];
          case (s_axis_tuser_i)
            CMD_PKT: begin
              idx_d = '0;
              if (count_q == '0) begin
                alloc_d = 1'b1;
                state_d = S_PKT;
              end else begin
                rd_en   = 1'b1;
                state_d = S_SCAN;
              end
            end
            CMD_EVAL: begin
              if (pend_q != '0) begin
                rd_en   = 1'b1;
                rd_idx  = pend_idx;
                idx_d   = pend_idx;
                state_d = S_EVAL;
              end
            end
            CMD_RPT: begin
              if (count_q != '0) begin
                rd_en   = 1'b1;
                idx_d   = '0;
                state_d = S_RPT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (addr_rd_q == in_addr_q) begin
          alloc_d = 1'b0;
          state_d = S_PKT;
        end else if (last_idx) begin
          if (count_q == CW'(TABLE_DEPTH)) begin
            state_d = S_DROP;
          end else begin
            alloc_d = 1'b1;
            idx_d   = count_q[IW-1:0];
            state_d = S_PKT;
          end
        end else begin
          rd_en  = 1'b1;
          rd_idx = idx_q + IW'(1);
          idx_d  = idx_q + IW'(1);
        end
      end
      S_PKT: begin
        if (out_free) begin
          wr_en  = 1'b1;
          wr_rec = upd;
          if (alloc_q) begin
            awr_en  = 1'b1;
            count_d = count_q + CW'(1);
          end
          pend_d = CW'(idx_q) + CW'(1);
          out_d = '0;
          out_d.kind       = KIND_PKT;
          out_d.entry_id   = out_id;
          out_d.entry_addr = SRC_W'(alloc_q ? in_addr_q : addr_rd_q);
          out_d.pkt_status = slot_st;
          out_d.recv_count = upd.recv;
          out_d.last       = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_DROP: begin
        if (out_free) begin
          out_d = '0;
          out_d.kind       = KIND_PKT;
          out_d.entry_addr = SRC_W'(in_addr_q);
          out_d.pkt_status = ST_DROP;
          out_d.last       = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_EVAL: begin
        score_d   = sc;
        div_start = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) state_d = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          wr_en        = 1'b1;
          wr_rec.slot1 = 8'd0;
          wr_rec.slot2 = 8'd0;
          wr_rec.slot3 = 8'd0;
          wr_rec.avg   = div_quo[6:0];
          wr_rec.div   = rec_rd_q.div + 8'd1;
          pend_d = '0;
          out_d = '0;
          out_d.kind        = KIND_EVAL;
          out_d.entry_id    = out_id;
          out_d.entry_addr  = SRC_W'(addr_rd_q);
          out_d.score       = score_q;
          out_d.ratio_avg   = div_quo[6:0];
          out_d.divider_out = rec_rd_q.div + 8'd1;
          out_d.last        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RPT: begin
        if (out_free) begin
          wr_en       = 1'b1;
          wr_rec.recv = 8'd0;
          out_d = '0;
          out_d.kind         = KIND_RPT;
          out_d.entry_id     = out_id;
          out_d.entry_addr   = SRC_W'(addr_rd_q);
          out_d.recv_count   = rec_rd_q.recv;
          out_d.report_ratio = ratio_prod[RATIO_SHIFT +: 10];
          out_d.last         = last_idx;
          out_valid_d = 1'b1;
          if (last_idx) begin
            state_d = S_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_idx = idx_q + IW'(1);
            idx_d  = idx_q + IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      alloc_q     <= 1'b0;
      in_addr_q   <= '0;
      in_seq_q    <= '0;
      score_q     <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      alloc_q     <= alloc_d;
      in_addr_q   <= in_addr_d;
      in_seq_q    <= in_seq_d;
      score_q     <= score_d;
      out_q       <= out_d;
    end
  end

  // entry memories: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (awr_en) addr_mem[idx_q] <= in_addr_q;
    if (wr_en)  data_mem[idx_q] <= wr_rec;
    if (rd_en) begin
      addr_rd_q <= addr_mem[rd_idx];
      rec_rd_q  <= data_mem[rd_idx];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {out_q.report_ratio, out_q.divider_out, out_q.ratio_avg,
                            out_q.score, out_q.recv_count, out_q.pkt_status,
                            out_q.entry_addr, out_q.entry_id};

endmodule

// ===== design/ndrt_checker.sv =====
// Port-level checks for the neighbour delivery ratio table, bound to the top.
// Depends on ndrt_pkg for result codes.
module ndrt_checker import ndrt_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic pkt_v, eval_v;
  assign pkt_v  = m_axis_tvalid_o && (m_axis_tuser_o == KIND_PKT);
  assign eval_v = m_axis_tvalid_o && (m_axis_tuser_o == KIND_EVAL);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transaction withdrawn while stalled");

  a_drop_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_v |-> ((m_axis_tdata_o[23:21] == ST_DROP) == (m_axis_tdata_o[4:0] == 5'd0)))
    else $error("dropped packet and entry id disagree");

  a_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_v |-> (m_axis_tdata_o[38:32] == SCORE_ALL || m_axis_tdata_o[38:32] == SCORE_SOME
                || m_axis_tdata_o[38:32] == SCORE_NONE))
    else $error("evaluation score out of set");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_v || eval_v) |-> m_axis_tlast_o)
    else $error("single-result transaction without tlast");

endmodule

bind neighbor_delivery_ratio_table ndrt_checker u_ndrt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

// ===== tb/neighbor_delivery_ratio_table_test.sv =====
// Testbench for the neighbour delivery ratio table: random and directed packets and ticks.
// Depends on ndrt_pkg and the neighbor_delivery_ratio_table top level.
module neighbor_delivery_ratio_table_test;
  import ndrt_pkg::*;

  localparam int DEPTH      = 16;
  localparam int WDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  seq;
  } req_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] data;
    logic        last;
  } resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  neighbor_delivery_ratio_table DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  req_t  pending_q[$];
  resp_t expected_q[$];
  int    errors = 0;
  int    wdog = 0;
  bit    calm = 1'b0;
  bit    hold_send = 1'b0;

  // predictor state
  int          n_entries = 0;
  int          pend = 0;
  logic [15:0] t_addr[DEPTH];
  logic [7:0]  t_recv[DEPTH], t_s1[DEPTH], t_s2[DEPTH], t_s3[DEPTH], t_div[DEPTH];
  logic [6:0]  t_avg[DEPTH];

  function automatic logic [63:0] pack_res(logic [4:0] id, logic [15:0] a, logic [2:0] st,
      logic [7:0] rc, logic [6:0] sc, logic [6:0] av, logic [7:0] dv, logic [9:0] rr);
    return {rr, dv, av, sc, rc, st, a, id};
  endfunction

  task automatic push_res(logic [1:0] k, logic [63:0] d, logic l);
    resp_t r;
    r.kind = k; r.data = d; r.last = l;
    expected_q.push_back(r);
  endtask

  task automatic predict_table(req_t q);
    int i;
    logic [2:0] st;
    logic [8:0] a, b, c;
    logic [6:0] sc;
    int num, den;
    case (q.cmd)
      CMD_PKT: begin
        i = 0;
        while (i < n_entries && t_addr[i] != q.addr) i++;
        if (i == n_entries && n_entries == DEPTH) begin
          push_res(KIND_PKT, pack_res(5'd0, q.addr, ST_DROP, 8'd0, 7'd0, 7'd0, 8'd0, 10'd0),
                   1'b1);
        end else begin
          if (i == n_entries) begin
            t_addr[i] = q.addr; t_recv[i] = 0; t_s1[i] = 0; t_s2[i] = 0; t_s3[i] = 0;
            t_avg[i] = AVG_INIT; t_div[i] = DIV_INIT; n_entries++;
          end
          t_recv[i] = t_recv[i] + 8'd1;
          if (t_s1[i] == 0) begin t_s1[i] = q.seq; st = ST_SLOT1; end
          else if (t_s2[i] == 0) begin t_s2[i] = q.seq; st = ST_SLOT2; end
          else if (t_s3[i] == 0) begin t_s3[i] = q.seq; st = ST_SLOT3; end
          else st = ST_FULL;
          pend = i + 1;
          push_res(KIND_PKT, pack_res(5'(i + 1), t_addr[i], st, t_recv[i], 7'd0, 7'd0,
                   8'd0, 10'd0), 1'b1);
        end
      end
      CMD_EVAL: if (pend != 0) begin
        i = pend - 1;
        a = t_s1[i]; b = t_s2[i]; c = t_s3[i];
        if (a + 1 == b && b + 1 == c && a + 2 == c) sc = SCORE_ALL;
        else if (a + 1 == b || b + 1 == c || a + 2 == c) sc = SCORE_SOME;
        else sc = SCORE_NONE;
        num = t_avg[i] * t_div[i] + sc;
        den = t_div[i] + 1;
        t_avg[i] = 7'(num / den);
        t_div[i] = t_div[i] + 8'd1;
        t_s1[i] = 0; t_s2[i] = 0; t_s3[i] = 0;
        pend = 0;
        push_res(KIND_EVAL, pack_res(5'(i + 1), t_addr[i], 3'd0, 8'd0, sc, t_avg[i],
                 t_div[i], 10'd0), 1'b1);
      end
      CMD_RPT: for (int k = 0; k < n_entries; k++) begin
        push_res(KIND_RPT, pack_res(5'(k + 1), t_addr[k], 3'd0, t_recv[k], 7'd0, 7'd0, 8'd0,
                 10'((t_recv[k] * 25) / 9)), k == n_entries - 1);
        t_recv[k] = 0;
      end
      default: ;
    endcase
  endtask

  // remembers whether the item on the bus was taken at the last edge
  logic s_axis_tready_o_d = 1'b0;
  int   dst_gap = 0;

  // driver
  int src_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        // accepted at the last rising edge; the monitor handles prediction
      end
      if (!s_axis_tvalid_i || s_axis_tready_o_d) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 11);
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() > 0 && !hold_send) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= pending_q[0].cmd;
          s_axis_tdata_i  <= {pending_q[0].seq, pending_q[0].addr};
          void'(pending_q.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    resp_t e;
    req_t  q;
    bit    moved;
    moved = 1'b0;
    s_axis_tready_o_d <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        q.cmd = s_axis_tuser_i; q.addr = s_axis_tdata_i[15:0]; q.seq = s_axis_tdata_i[23:16];
        predict_table(q);
        moved = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved = 1'b1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result kind %0d data %h", $time, m_axis_tuser_o,
                   m_axis_tdata_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (e.kind != m_axis_tuser_o || e.data != m_axis_tdata_o
              || e.last != m_axis_tlast_o) begin
            $display("%0t: mismatch expected kind %0d data %h last %0d,", $time,
                     e.kind, e.data, e.last);
            $display("  actual kind %0d data %h last %0d", m_axis_tuser_o,
                     m_axis_tdata_o, m_axis_tlast_o);
            errors++;
          end
        end
      end
      wdog <= moved ? 0 : wdog + 1;
    end
  end

  // receiver stalls change at the falling edge
  always @(negedge clk_i) begin
    if (dst_gap > 0) begin
      dst_gap--;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      dst_gap = $urandom_range(1, 11);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (wdog >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] c, logic [15:0] a, logic [7:0] s);
    req_t q;
    q.cmd = c; q.addr = a; q.seq = s;
    pending_q.push_back(q);
  endtask

  initial begin
    logic [7:0]  base;
    logic [15:0] ad;
    int          pick;
    // directed: empty report, nothing pending, unused command
    add_item(CMD_RPT, 16'h0, 8'h0);
    add_item(CMD_EVAL, 16'hffff, 8'hff);
    add_item(CMD_RSVD, 16'hffff, 8'hff);
    // consecutive run, then seq zero and slots full
    add_item(CMD_PKT, 16'h0000, 8'd1);
    add_item(CMD_PKT, 16'h0000, 8'd2);
    add_item(CMD_PKT, 16'h0000, 8'd3);
    add_item(CMD_PKT, 16'h0000, 8'd9);
    add_item(CMD_EVAL, 16'h0, 8'h0);
    add_item(CMD_PKT, 16'hffff, 8'd0);
    add_item(CMD_PKT, 16'hffff, 8'd254);
    add_item(CMD_PKT, 16'hffff, 8'd255);
    add_item(CMD_EVAL, 16'h0, 8'h0);
    add_item(CMD_PKT, 16'h1234, 8'd255);
    add_item(CMD_PKT, 16'h1234, 8'd0);
    add_item(CMD_PKT, 16'h1234, 8'd1);
    add_item(CMD_PKT, 16'h1234, 8'd40);
    add_item(CMD_EVAL, 16'h0, 8'h0);
    add_item(CMD_RPT, 16'h0, 8'h0);
    // fill the table past its depth
    for (int k = 0; k < 15; k++) add_item(CMD_PKT, 16'(16'h8000 + k), 8'(k + 1));
    add_item(CMD_PKT, 16'h5555, 8'haa);
    add_item(CMD_RPT, 16'h0, 8'h0);
    for (int k = 0; k < 170; k++) begin
      pick = $urandom_range(0, 19);
      ad = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                       : 16'(16'h8000 + $urandom_range(0, 15));
      if (pick < 3) begin
        base = 8'($urandom);
        add_item(CMD_PKT, ad, base);
        add_item(CMD_PKT, ad, base + 8'd1);
        add_item(CMD_PKT, ad, ($urandom_range(0, 1)) ? base + 8'd2 : 8'($urandom));
        add_item(CMD_EVAL, 16'($urandom), 8'($urandom));
      end else if (pick < 12) add_item(CMD_PKT, ad, 8'($urandom));
      else if (pick < 17) add_item(CMD_EVAL, 16'($urandom), 8'($urandom));
      else if (pick < 19) add_item(CMD_RPT, 16'($urandom), 8'($urandom));
      else add_item(CMD_RSVD, 16'($urandom), 8'($urandom));
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    // pause the sender once until the table has drained
    wait (pending_q.size() < 200);
    hold_send = 1'b1;
    wait (expected_q.size() == 0 && !s_axis_tvalid_i);
    repeat (40) @(posedge clk_i);
    hold_send = 1'b0;
    wait (pending_q.size() < 60);
    calm = 1'b1;
    wait (pending_q.size() == 0 && !s_axis_tvalid_i);
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
